// ===== rtl/scl_pkg.sv =====
package scl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W      = 48;
  localparam int CODE_CHARS  = 6;
  localparam int COUNT_OUT_W = 11;
  localparam int STATUS_W    = 3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // controller status seen by the top level
  typedef struct packed {
    logic             idle;
    logic             wr;
    logic [CNT_W-1:0] count;
  } scl_stat_t;

  // two letters then four digits, first character in the top byte
  function automatic logic code_is_valid(input logic [CODE_W-1:0] c);
    logic       ok;
    logic [7:0] ch;
    ok = 1'b1;
    for (int pos = 0; pos < CODE_CHARS; pos++) begin
      ch = c[8*(CODE_CHARS-1-pos) +: 8];
      if (pos < 2) begin
        if (ch < 8'h41 || ch > 8'h5A) ok = 1'b0;
      end else begin
        if (ch < 8'h30 || ch > 8'h39) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== rtl/scl_ram.sv =====
module scl_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scl_ctrl.sv =====
module scl_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [scl_pkg::CODE_W-1:0]          in_code,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scl_pkg::STATUS_W-1:0]        out_status,
  output logic [scl_pkg::COUNT_OUT_W-1:0]     out_count,
  output logic                                ram_we,
  output logic [scl_pkg::IDX_W-1:0]           ram_waddr,
  output logic [scl_pkg::CODE_W-1:0]          ram_wdata,
  output logic                                ram_re,
  output logic [scl_pkg::IDX_W-1:0]           ram_raddr,
  input  logic [scl_pkg::CODE_W-1:0]          ram_rdata,
  output scl_pkg::scl_stat_t                  stat
);

  localparam int CNT_W = scl_pkg::CNT_W;
  localparam int IDX_W = scl_pkg::IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]                    state;
  logic [CNT_W-1:0]              count;
  logic                          kind;
  logic [scl_pkg::CODE_W-1:0]    code;
  logic [CNT_W-1:0]              lo;
  logic [CNT_W-1:0]              hi;
  logic [IDX_W-1:0]              mid;
  logic [CNT_W-1:0]              rem;
  logic [IDX_W-1:0]              rd_ptr;
  logic                          pend;
  logic [IDX_W-1:0]              pend_addr;
  logic [scl_pkg::STATUS_W-1:0]  res_status;

  logic [CNT_W-1:0] mid_next;
  logic             cmp_lt;
  logic             cmp_eq;
  logic             out_free;
  logic             resp_fire;

  // shared compare unit: search key against the entry just read
  assign cmp_lt    = code < ram_rdata;
  assign cmp_eq    = code == ram_rdata;
  assign mid_next  = lo + ((hi - lo) >> 1);
  assign out_free  = !out_valid || out_ready;
  assign resp_fire = (state == S_RESP) && out_free;

  assign in_ready   = (state == S_IDLE);
  assign stat.idle  = (state == S_IDLE);
  assign stat.wr    = ram_we;
  assign stat.count = count;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr + IDX_W'(1);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = mid_next[IDX_W-1:0];
    unique case (state)
      S_SRCH: begin
        ram_re = (lo < hi);
      end
      S_SHIFT: begin
        ram_we    = pend;
        ram_re    = (rem != '0);
        ram_raddr = rd_ptr;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = lo[IDX_W-1:0];
        ram_wdata = code;
      end
      default: begin
      end
    endcase
  end

  // output register: loaded from S_RESP, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind <= in_kind;
            code <= in_code;
            lo   <= '0;
            hi   <= count;
            if (in_kind == scl_pkg::KIND_QUERY) begin
              state <= S_SRCH;
            end else if (!scl_pkg::code_is_valid(in_code)) begin
              res_status <= scl_pkg::ST_INVALID;
              state      <= S_RESP;
            end else if (count >= CNT_W'(scl_pkg::TABLE_DEPTH)) begin
              res_status <= scl_pkg::ST_FULL;
              state      <= S_RESP;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_next[IDX_W-1:0];
            state <= S_CMP;
          end else if (kind == scl_pkg::KIND_QUERY) begin
            res_status <= scl_pkg::ST_NOT_FOUND;
            state      <= S_RESP;
          end else begin
            // lo is the upper bound; move entries lo..count-1 up by one
            rem    <= count - lo;
            rd_ptr <= IDX_W'(count - CNT_W'(1));
            pend   <= 1'b0;
            state  <= S_SHIFT;
          end
        end
        S_CMP: begin
          // query stops on a hit; insert treats equal as "go right"
          if (kind == scl_pkg::KIND_QUERY && cmp_eq) begin
            res_status <= scl_pkg::ST_FOUND;
            state      <= S_RESP;
          end else begin
            state <= S_SRCH;
            if (cmp_lt) hi <= CNT_W'(mid);
            else        lo <= CNT_W'(mid) + CNT_W'(1);
          end
        end
        S_SHIFT: begin
          // read of rd_ptr overlaps write of the previous read to its slot + 1
          if (rem != '0) begin
            pend      <= 1'b1;
            pend_addr <= rd_ptr;
            rd_ptr    <= rd_ptr - IDX_W'(1);
            rem       <= rem - CNT_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) state <= S_PLACE;
          end
        end
        S_PLACE: begin
          count      <= count + CNT_W'(1);
          res_status <= scl_pkg::ST_STORED;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_status <= res_status;
            out_count  <= scl_pkg::COUNT_OUT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sorted_code_catalog_lookup_top.sv =====
// channel  dir  tdata                      tuser
// s_       in   [47:0] code                [0] kind (0 insert, 1 query)
// m_       out  [10:0] entry_count, pad    [2:0] status
//
// Query: a binary search, one RAM read and one compare per step.
// Insert: the search, then the tail from the insertion point moves up a slot (a read and a
// write per cycle), then the code is placed. Invalid or full inserts go straight to the response.
// Reset (rst, synchronous) empties the catalog.
// s_tready is high only while the controller is idle; a waiting result does not block
// acceptance, the next result waits for the output register to drain.
module sorted_code_catalog_lookup_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [47:0] code
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [10:0] entry_count, [15:11] zero
  output logic [2:0]  m_tuser    // [2:0] status
);

  logic                              ram_we;
  logic [scl_pkg::IDX_W-1:0]         ram_waddr;
  logic [scl_pkg::CODE_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [scl_pkg::IDX_W-1:0]         ram_raddr;
  logic [scl_pkg::CODE_W-1:0]        ram_rdata;
  logic [scl_pkg::COUNT_OUT_W-1:0]   out_count;
  scl_pkg::scl_stat_t                stat;

  scl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser[0]),
    .in_code    (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_count  (out_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .stat       (stat)
  );

  // sorted code table
  scl_ram #(
    .DEPTH  (scl_pkg::TABLE_DEPTH),
    .WIDTH  (scl_pkg::CODE_W),
    .ADDR_W (scl_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tdata = {5'b0, out_count};

  // catalog never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= scl_pkg::CNT_W'(scl_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  // controller goes busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accept");

  // table is written only while an insert is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    stat.wr |-> !stat.idle)
    else $error("table write while idle");

  // a stored entry raises the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    stat.count != $past(stat.count) |-> stat.count == $past(stat.count) + 1'b1)
    else $error("count changed by other than one");

endmodule
